// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the maze generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- hw/rtl/gmb_pkg.sv -----
// Shared types and constants for the grid maze backtracker.
`default_nettype none

package gmb_pkg;

  // Default grid capacity
  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;

  // Field and register widths
  localparam int CFG_W    = 6;
  localparam int COORD_W  = 5;
  localparam int DEPTH_W  = 11;
  localparam int DIR_W    = 2;
  localparam int OP_W     = 2;
  localparam int NUM_DIRS = 4;

  // APB port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Register reset values
  localparam logic [CFG_W-1:0] ROWS_RST = 6'd10;
  localparam logic [CFG_W-1:0] COLS_RST = 6'd20;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2
  } gmb_op_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } gmb_dir_t;

  // Input beat
  typedef struct packed {
    logic [OP_W-1:0]    cmd;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DIR_W-1:0]   dir;
  } gmb_in_t;

  // Result beat
  typedef struct packed {
    logic               moved;
    logic [COORD_W-1:0] cur_row;
    logic [COORD_W-1:0] cur_col;
    logic               done_res;
    logic               top_wall;
    logic               left_wall;
    logic [DEPTH_W-1:0] stack_depth;
  } gmb_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic clr_start;
    logic clr_step;
    logic seed;
    logic mv_probe;
    logic mv_commit;
    logic scan_start;
    logic scan_step;
    logic pop;
    logic load_top;
    logic rd_cell;
    logic wall_cap;
    logic capture;
  } gmb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sp_zero;
    logic sp_one;
    logic clr_last;
    logic scan_hit;
    logic scan_end;
  } gmb_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/grid_maze_backtracker.sv -----
// Top level of the grid maze backtracker: register file, controller, datapath.
//
//  Channel   Handshake                 Payload       Notes
//  input     start / busy              in_data       taken when start && !busy
//  result    out_valid (1-cycle)       out_data      no back pressure
//  config    psel/penable/pwrite/...   pwdata[5:0]   grid_rows @0, grid_cols @4
//
// A step probes and commits its move, then scans the stack top's neighbors; each
// cell popped (empty four-way scan, pop, reload) adds to the wait for the result.
// A step on an empty stack goes straight to the result. A read fetches the walls.
// A start sweeps every cell (MAX_ROWS*MAX_COLS, 1024 at default) before seeding;
// after reset the same sweep runs with busy high and no result.
// busy falls in the cycle that shows the result; results cannot be stalled.
`default_nettype none

module grid_maze_backtracker #(
  parameter int MAX_ROWS = gmb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gmb_pkg::DEF_MAX_COLS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  gmb_pkg::gmb_in_t            in_data,
  output logic                        out_valid,
  output gmb_pkg::gmb_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gmb_pkg::ADDR_W-1:0]  paddr,
  input  logic [gmb_pkg::DATA_W-1:0]  pwdata,
  output logic [gmb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import gmb_pkg::*;

  logic [CFG_W-1:0] grid_rows;
  logic [CFG_W-1:0] grid_cols;
  gmb_cmd_t         dp_cmd;
  gmb_sts_t         dp_sts;

  // Grid size registers
  gmb_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .grid_rows (grid_rows),
    .grid_cols (grid_cols)
  );

  // Sequencer
  gmb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_data.cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  // Cell memories, stack and result register
  gmb_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .grid_rows (grid_rows),
    .grid_cols (grid_cols),
    .in_data   (in_data),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/gmb_cfg.sv -----
// APB register file holding the grid size registers.
`default_nettype none

module gmb_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gmb_pkg::ADDR_W-1:0]  paddr,
  input  logic [gmb_pkg::DATA_W-1:0]  pwdata,
  output logic [gmb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [gmb_pkg::CFG_W-1:0]   grid_rows,
  output logic [gmb_pkg::CFG_W-1:0]   grid_cols
);
  import gmb_pkg::*;

  // Registers sit on 4-byte strides; bit 2 picks the register
  localparam int   IDX_BIT  = 2;
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Write decode
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (wr_en) begin
      case (paddr[IDX_BIT])
        REG_ROWS: rows_nxt = pwdata[CFG_W-1:0];
        REG_COLS: cols_nxt = pwdata[CFG_W-1:0];
        default:  rows_nxt = rows_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROWS_RST;
      cols_r <= COLS_RST;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // Read mux
  always_comb begin
    case (paddr[IDX_BIT])
      REG_ROWS: prdata = {{(DATA_W-CFG_W){1'b0}}, rows_r};
      REG_COLS: prdata = {{(DATA_W-CFG_W){1'b0}}, cols_r};
      default:  prdata = '0;
    endcase
  end

  assign grid_rows = rows_r;
  assign grid_cols = cols_r;

endmodule

`default_nettype wire

// ----- hw/rtl/gmb_dp.sv -----
// Datapath: cell memories, path stack, neighbor logic and result register.
`default_nettype none
`include "assert_macros.svh"

module gmb_dp #(
  parameter int MAX_ROWS = gmb_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gmb_pkg::DEF_MAX_COLS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [gmb_pkg::CFG_W-1:0]  grid_rows,
  input  logic [gmb_pkg::CFG_W-1:0]  grid_cols,
  input  gmb_pkg::gmb_in_t           in_data,
  input  gmb_pkg::gmb_cmd_t          dp_cmd,
  output gmb_pkg::gmb_sts_t          dp_sts,
  output gmb_pkg::gmb_out_t          out_data
);
  import gmb_pkg::*;

  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CELL_W = $clog2(CELLS);
  localparam int SP_W   = $clog2(CELLS + 1);
  localparam int ENT_W  = ROW_W + COL_W;
  localparam int SCAN_W = $clog2(NUM_DIRS + 1);

  typedef struct packed {
    logic             ok;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } nbr_t;

  // Saturate a coordinate to the last row or column in use
  function automatic logic [ROW_W-1:0] clamp_row(input logic [COORD_W-1:0] v,
                                                 input logic [ROW_W:0] lim);
    if (int'(v) >= int'(lim)) return ROW_W'(lim - (ROW_W+1)'(1));
    return ROW_W'(v);
  endfunction

  function automatic logic [COL_W-1:0] clamp_col(input logic [COORD_W-1:0] v,
                                                 input logic [COL_W:0] lim);
    if (int'(v) >= int'(lim)) return COL_W'(lim - (COL_W+1)'(1));
    return COL_W'(v);
  endfunction

  function automatic logic [CELL_W-1:0] cell_idx(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return CELL_W'(r) * CELL_W'(MAX_COLS) + CELL_W'(c);
  endfunction

  // Neighbor cell in one direction and whether it lies in the grid in use
  function automatic nbr_t neighbor(input logic [ROW_W-1:0] r,
                                    input logic [COL_W-1:0] c,
                                    input logic [DIR_W-1:0] d,
                                    input logic [ROW_W:0]   lim_r,
                                    input logic [COL_W:0]   lim_c);
    logic [ROW_W:0] nr;
    logic [COL_W:0] nc;
    logic           under;
    nbr_t           n;
    nr    = {1'b0, r};
    nc    = {1'b0, c};
    under = 1'b0;
    case (gmb_dir_t'(d))
      DIR_UP: begin
        under = (r == '0);
        nr    = {1'b0, r} - (ROW_W+1)'(1);
      end
      DIR_RIGHT: nc = {1'b0, c} + (COL_W+1)'(1);
      DIR_DOWN:  nr = {1'b0, r} + (ROW_W+1)'(1);
      DIR_LEFT: begin
        under = (c == '0);
        nc    = {1'b0, c} - (COL_W+1)'(1);
      end
      default: under = 1'b1;
    endcase
    n.ok  = !under && (nr < lim_r) && (nc < lim_c);
    n.row = nr[ROW_W-1:0];
    n.col = nc[COL_W-1:0];
    return n;
  endfunction

  // Memories
  logic             vis_mem  [CELLS];
  logic             top_mem  [CELLS];
  logic             left_mem [CELLS];
  logic [ENT_W-1:0] stk_mem  [CELLS];

  logic             vis_rd_r, tw_rd_r, lw_rd_r;
  logic [ENT_W-1:0] stk_rd_r;

  // State registers
  logic [ROW_W-1:0]  cell_row_r, cell_row_nxt;
  logic [COL_W-1:0]  cell_col_r, cell_col_nxt;
  logic [DIR_W-1:0]  dir_r, dir_nxt;
  logic [ROW_W-1:0]  top_row_r, top_row_nxt;
  logic [COL_W-1:0]  top_col_r, top_col_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic [CELL_W-1:0] clear_idx_r, clear_idx_nxt;
  logic [SCAN_W-1:0] scan_k_r, scan_k_nxt;
  logic              probe_live_r, probe_live_nxt;
  logic              moved_r, moved_nxt;
  logic              tw_r, tw_nxt;
  logic              lw_r, lw_nxt;
  nbr_t              mv_r, mv_nxt;
  gmb_out_t          out_r;
  gmb_out_t          res;

  logic [ROW_W:0]    eff_rows;
  logic [COL_W:0]    eff_cols;
  nbr_t              mv_nbr, scan_nbr;
  logic              scan_probe, scan_hit, commit_go, push_ok, sp_zero;
  logic [SP_W-1:0]   sp_m1, sp_m2;
  logic [CELL_W-1:0] top_idx, mv_idx, cell_ix;

  logic              vis_we, vis_wd, vis_re;
  logic [CELL_W-1:0] vis_wa, vis_ra;
  logic              tw_we, tw_wd, lw_we, lw_wd;
  logic [CELL_W-1:0] tw_wa, lw_wa;
  logic              stk_we;
  logic [CELL_W-1:0] stk_wa;
  logic [ENT_W-1:0]  stk_wd;

  // Grid size in use: zero acts as one, above capacity saturates
  always_comb begin
    if (grid_rows == '0)                eff_rows = (ROW_W+1)'(1);
    else if (int'(grid_rows) > MAX_ROWS) eff_rows = (ROW_W+1)'(MAX_ROWS);
    else                                 eff_rows = (ROW_W+1)'(grid_rows);
    if (grid_cols == '0)                eff_cols = (COL_W+1)'(1);
    else if (int'(grid_cols) > MAX_COLS) eff_cols = (COL_W+1)'(MAX_COLS);
    else                                 eff_cols = (COL_W+1)'(grid_cols);
  end

  // Neighbor and index logic
  assign mv_nbr     = neighbor(top_row_r, top_col_r, dir_r, eff_rows, eff_cols);
  assign scan_nbr   = neighbor(top_row_r, top_col_r, scan_k_r[DIR_W-1:0],
                               eff_rows, eff_cols);
  assign top_idx    = cell_idx(top_row_r, top_col_r);
  assign mv_idx     = cell_idx(mv_r.row, mv_r.col);
  assign cell_ix    = cell_idx(cell_row_r, cell_col_r);
  assign scan_probe = dp_cmd.scan_step && (scan_k_r != SCAN_W'(NUM_DIRS));
  assign scan_hit   = probe_live_r && !vis_rd_r;
  assign commit_go  = dp_cmd.mv_commit && mv_r.ok && !vis_rd_r;
  assign push_ok    = sp_r < SP_W'(CELLS);
  assign sp_zero    = (sp_r == '0);
  assign sp_m1      = sp_r - SP_W'(1);
  assign sp_m2      = sp_r - SP_W'(2);

  // Visited bits: clearing sweep, seed and move share the write port
  always_comb begin
    vis_we = 1'b0;
    vis_wa = clear_idx_r;
    vis_wd = 1'b0;
    if (dp_cmd.clr_step) begin
      vis_we = 1'b1;
    end else if (dp_cmd.seed) begin
      vis_we = 1'b1;
      vis_wa = cell_ix;
      vis_wd = 1'b1;
    end else if (commit_go) begin
      vis_we = 1'b1;
      vis_wa = mv_idx;
      vis_wd = 1'b1;
    end
    vis_re = dp_cmd.mv_probe || scan_probe;
    vis_ra = dp_cmd.mv_probe ? cell_idx(mv_nbr.row, mv_nbr.col)
                             : cell_idx(scan_nbr.row, scan_nbr.col);
  end

  // Wall bits: raised by the sweep, knocked down by a move
  always_comb begin
    tw_we = 1'b0;
    tw_wa = clear_idx_r;
    tw_wd = 1'b1;
    lw_we = 1'b0;
    lw_wa = clear_idx_r;
    lw_wd = 1'b1;
    if (dp_cmd.clr_step) begin
      tw_we = 1'b1;
      lw_we = 1'b1;
    end else if (commit_go) begin
      case (gmb_dir_t'(dir_r))
        DIR_UP: begin
          tw_we = 1'b1;
          tw_wa = top_idx;
          tw_wd = 1'b0;
        end
        DIR_DOWN: begin
          tw_we = 1'b1;
          tw_wa = mv_idx;
          tw_wd = 1'b0;
        end
        DIR_RIGHT: begin
          lw_we = 1'b1;
          lw_wa = mv_idx;
          lw_wd = 1'b0;
        end
        DIR_LEFT: begin
          lw_we = 1'b1;
          lw_wa = top_idx;
          lw_wd = 1'b0;
        end
        default: tw_we = 1'b0;
      endcase
    end
  end

  // Stack write: seed at the bottom, pushes at the pointer
  always_comb begin
    stk_we = dp_cmd.seed || (commit_go && push_ok);
    stk_wa = dp_cmd.seed ? '0 : sp_r[CELL_W-1:0];
    stk_wd = dp_cmd.seed ? {cell_row_r, cell_col_r} : {mv_r.row, mv_r.col};
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    if (vis_re) vis_rd_r <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (tw_we) top_mem[tw_wa] <= tw_wd;
    if (dp_cmd.rd_cell) tw_rd_r <= top_mem[cell_ix];
  end

  always_ff @(posedge clk) begin
    if (lw_we) left_mem[lw_wa] <= lw_wd;
    if (dp_cmd.rd_cell) lw_rd_r <= left_mem[cell_ix];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (dp_cmd.pop) stk_rd_r <= stk_mem[sp_m2[CELL_W-1:0]];
  end

  // Next state of the walk registers
  always_comb begin
    cell_row_nxt   = cell_row_r;
    cell_col_nxt   = cell_col_r;
    dir_nxt        = dir_r;
    top_row_nxt    = top_row_r;
    top_col_nxt    = top_col_r;
    sp_nxt         = sp_r;
    clear_idx_nxt  = clear_idx_r;
    scan_k_nxt     = scan_k_r;
    probe_live_nxt = probe_live_r;
    moved_nxt      = moved_r;
    tw_nxt         = tw_r;
    lw_nxt         = lw_r;
    mv_nxt         = mv_r;

    if (dp_cmd.load_in) begin
      cell_row_nxt = clamp_row(in_data.row, eff_rows);
      cell_col_nxt = clamp_col(in_data.col, eff_cols);
      dir_nxt      = in_data.dir;
      moved_nxt    = 1'b0;
      tw_nxt       = 1'b0;
      lw_nxt       = 1'b0;
    end

    if (dp_cmd.clr_start)     clear_idx_nxt = '0;
    else if (dp_cmd.clr_step) clear_idx_nxt = clear_idx_r + CELL_W'(1);

    if (dp_cmd.seed) begin
      sp_nxt      = SP_W'(1);
      top_row_nxt = cell_row_r;
      top_col_nxt = cell_col_r;
    end

    if (dp_cmd.mv_probe) mv_nxt = mv_nbr;

    if (commit_go) begin
      moved_nxt = 1'b1;
      if (push_ok) begin
        sp_nxt      = sp_r + SP_W'(1);
        top_row_nxt = mv_r.row;
        top_col_nxt = mv_r.col;
      end
    end

    // One visited probe issued per scan cycle, checked the cycle after
    if (dp_cmd.scan_start) begin
      scan_k_nxt     = '0;
      probe_live_nxt = 1'b0;
    end else if (dp_cmd.scan_step) begin
      probe_live_nxt = scan_probe && scan_nbr.ok;
      if (scan_probe) scan_k_nxt = scan_k_r + SCAN_W'(1);
    end

    if (dp_cmd.pop)      sp_nxt = sp_m1;
    if (dp_cmd.load_top) {top_row_nxt, top_col_nxt} = stk_rd_r;

    if (dp_cmd.wall_cap) begin
      tw_nxt = tw_rd_r;
      lw_nxt = lw_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r         <= '0;
      clear_idx_r  <= '0;
      scan_k_r     <= '0;
      probe_live_r <= 1'b0;
    end else begin
      sp_r         <= sp_nxt;
      clear_idx_r  <= clear_idx_nxt;
      scan_k_r     <= scan_k_nxt;
      probe_live_r <= probe_live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_row_r <= cell_row_nxt;
    cell_col_r <= cell_col_nxt;
    dir_r      <= dir_nxt;
    top_row_r  <= top_row_nxt;
    top_col_r  <= top_col_nxt;
    moved_r    <= moved_nxt;
    tw_r       <= tw_nxt;
    lw_r       <= lw_nxt;
    mv_r       <= mv_nxt;
  end

  // Result beat
  always_comb begin
    res.moved       = moved_r;
    res.cur_row     = sp_zero ? '0 : COORD_W'(top_row_r);
    res.cur_col     = sp_zero ? '0 : COORD_W'(top_col_r);
    res.done_res    = sp_zero;
    res.top_wall    = tw_r;
    res.left_wall   = lw_r;
    res.stack_depth = DEPTH_W'(sp_r);
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.capture) out_r <= res;
  end

  assign out_data = out_r;

  // Status to the controller
  assign dp_sts.sp_zero  = sp_zero;
  assign dp_sts.sp_one   = (sp_r == SP_W'(1));
  assign dp_sts.clr_last = (clear_idx_r == CELL_W'(CELLS - 1));
  assign dp_sts.scan_hit = scan_hit;
  assign dp_sts.scan_end = (scan_k_r == SCAN_W'(NUM_DIRS)) && !scan_hit;

  `ASSERT_CLK(a_sp_bound, sp_r <= SP_W'(CELLS), "stack pointer beyond cell count")
  `ASSERT_NEVER(a_pop_empty, dp_cmd.pop && sp_zero, "pop issued on an empty stack")

endmodule

`default_nettype wire

// ----- hw/rtl/gmb_ctrl.sv -----
// Controller state machine sequencing clear, move, backtrack and read.
`default_nettype none
`include "assert_macros.svh"

module gmb_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [gmb_pkg::OP_W-1:0] op,
  output logic                     busy,
  output logic                     out_valid,
  output gmb_pkg::gmb_cmd_t        dp_cmd,
  input  gmb_pkg::gmb_sts_t        dp_sts
);
  import gmb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_MV_PROBE,
    ST_MV_COMMIT,
    ST_SCAN,
    ST_POP,
    ST_LOAD,
    ST_RD_CELL,
    ST_RD_CAP,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   seed_r, seed_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    seed_nxt      = seed_r;
    out_valid_nxt = 1'b0;
    dp_cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          dp_cmd.load_in = 1'b1;
          case (gmb_op_t'(op))
            OP_START: begin
              dp_cmd.clr_start = 1'b1;
              seed_nxt         = 1'b1;
              state_nxt        = ST_CLEAR;
            end
            OP_STEP:  state_nxt = dp_sts.sp_zero ? ST_FIN : ST_MV_PROBE;
            OP_READ:  state_nxt = ST_RD_CELL;
            default:  state_nxt = ST_FIN;
          endcase
        end
      end
      // One cell a cycle; after reset the sweep ends in idle
      ST_CLEAR: begin
        dp_cmd.clr_step = 1'b1;
        if (dp_sts.clr_last) state_nxt = seed_r ? ST_SEED : ST_IDLE;
      end
      ST_SEED: begin
        dp_cmd.seed       = 1'b1;
        dp_cmd.scan_start = 1'b1;
        seed_nxt          = 1'b0;
        state_nxt         = ST_SCAN;
      end
      ST_MV_PROBE: begin
        dp_cmd.mv_probe = 1'b1;
        state_nxt       = ST_MV_COMMIT;
      end
      ST_MV_COMMIT: begin
        dp_cmd.mv_commit  = 1'b1;
        dp_cmd.scan_start = 1'b1;
        state_nxt         = ST_SCAN;
      end
      // Look for an unvisited neighbor of the stack top
      ST_SCAN: begin
        dp_cmd.scan_step = 1'b1;
        if (dp_sts.scan_hit)      state_nxt = ST_FIN;
        else if (dp_sts.scan_end) state_nxt = ST_POP;
      end
      ST_POP: begin
        dp_cmd.pop = 1'b1;
        state_nxt  = dp_sts.sp_one ? ST_FIN : ST_LOAD;
      end
      ST_LOAD: begin
        dp_cmd.load_top   = 1'b1;
        dp_cmd.scan_start = 1'b1;
        state_nxt         = ST_SCAN;
      end
      ST_RD_CELL: begin
        dp_cmd.rd_cell = 1'b1;
        state_nxt      = ST_RD_CAP;
      end
      ST_RD_CAP: begin
        dp_cmd.wall_cap = 1'b1;
        state_nxt       = ST_FIN;
      end
      ST_FIN: begin
        dp_cmd.capture = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      seed_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  `ASSERT_CLK(a_strobe_pulse, out_valid_r |=> !out_valid_r, "result strobe longer than one cycle")
  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `ASSERT_CLK(a_strobe_idle, out_valid_r |-> !busy, "result strobe while still busy")

endmodule

`default_nettype wire
